// ===== rtl/gecs_pkg.sv =====
// shared types and constants of the grouped checked sum block
`default_nettype none
package gecs_pkg;
    localparam int MaxLen    = 32;
    localparam int NumGroups = 16;
    localparam int PosW      = $clog2(MaxLen);
    localparam int LenW      = 6;
    localparam int GrpW      = 4;
    localparam int AddrW     = GrpW + PosW;
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);

    localparam logic [1:0] CMD_ACC  = 2'd0;
    localparam logic [1:0] CMD_EXT  = 2'd1;
    localparam logic [1:0] CMD_INIT = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] ET_W8  = 2'd0;
    localparam logic [1:0] ET_W16 = 2'd1;
    localparam logic [1:0] ET_W32 = 2'd2;
    localparam logic [1:0] ET_W64 = 2'd3;

    localparam logic [2:0] KIND_SUM   = 3'd0;
    localparam logic [2:0] KIND_NULL  = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_OVFH  = 3'd3;
    localparam logic [2:0] KIND_OVFL  = 3'd4;
    localparam logic [2:0] KIND_CAP   = 3'd5;

    localparam logic CFG_ELEM_TYPE  = 1'b0;
    localparam logic CFG_PRESET_LEN = 1'b1;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_ACC,
        OP_EXT,
        OP_INIT,
        OP_CAP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [GrpW-1:0]  grp;
        logic [PosW-1:0]  pos;
        logic [LenW-1:0]  rlen;
        logic [63:0]      value;
        logic             enull;
    } item_t;

    // low width bits sign-extended to 64
    function automatic logic [63:0] narrow(input logic [63:0] v, input logic [1:0] et);
        logic [63:0] r;
        begin
            case (et)
                ET_W8:   r = {{56{v[7]}}, v[7:0]};
                ET_W16:  r = {{48{v[15]}}, v[15:0]};
                ET_W32:  r = {{32{v[31]}}, v[31:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/grouped_elementwise_checked_sum.sv =====
// top level of the grouped element-wise checked sum block
//
// channel | direction | transfer condition
// cmd     | in        | start && !busy
// result  | out       | strobe (one cycle, cannot be held off)
// config  | in        | cfg_valid && cfg_ready
//
// in the back end accumulate reads, adds and writes back the sum, extract steps through
// the group's sums in order, and init runs a clearing sweep over the group's 32 sums.
// a 4-entry queue decouples command transfer from the back end; busy rises when it fills.
// reset clears the queue and group state; a sweep then zeroes all 512 sum memory
// entries before the back end takes its first command.
// results cannot be stalled; the back end drives them directly from registers.
`default_nettype none
module grouped_elementwise_checked_sum (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  cmd,
    input  wire  [3:0]  group,
    input  wire  [4:0]  position,
    input  wire  [5:0]  row_length,
    input  wire  [63:0] elem_value,
    input  wire         elem_null,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [5:0]  cfg_data,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [4:0]  out_position,
    output logic [63:0] sum_value,
    output logic        last
);
    import gecs_pkg::*;

    logic [1:0]  element_type_reg;
    logic [5:0]  preset_length_reg;
    logic        q_valid, q_pop, idle;
    item_t       q_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg  <= ET_W64;
            preset_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index[0])
                CFG_ELEM_TYPE:  element_type_reg  <= cfg_data[1:0];
                default:        preset_length_reg <= cfg_data;
            endcase
        end
    end

    gecs_front u_front (
        .clk, .rst_n, .start, .busy, .cmd, .group, .position, .row_length,
        .elem_value, .elem_null, .q_valid, .q_item, .q_pop
    );

    gecs_back u_back (
        .clk, .rst_n,
        .element_type  (element_type_reg),
        .preset_length (preset_length_reg),
        .q_valid, .q_item, .q_pop, .idle,
        .strobe, .kind, .out_position, .sum_value, .last
    );

    // results only strobe while the back end is working
    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(idle) && idle |-> !strobe) else $error("result while idle");
    // kind stays in the defined range
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> kind <= KIND_CAP) else $error("bad result kind");
    // non-sum results always end their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind != KIND_SUM |-> last) else $error("missing last");
endmodule
`default_nettype wire

// ===== rtl/gecs_front.sv =====
// front end: accepts commands, classifies them and queues them for the back end
`default_nettype none
module gecs_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire  [1:0]            cmd,
    input  wire  [3:0]            group,
    input  wire  [4:0]            position,
    input  wire  [5:0]            row_length,
    input  wire  [63:0]           elem_value,
    input  wire                   elem_null,
    output logic                  q_valid,
    output gecs_pkg::item_t       q_item,
    input  wire                   q_pop
);
    import gecs_pkg::*;

    item_t            q_mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             push;
    item_t            cls;

    // classify the incoming command
    always_comb
    begin
        cls.grp   = group;
        cls.pos   = position;
        cls.rlen  = row_length;
        cls.value = elem_value;
        cls.enull = elem_null;
        case (cmd)
            CMD_ACC:  cls.op = (row_length > LenW'(MaxLen)) ? OP_CAP : OP_ACC;
            CMD_EXT:  cls.op = OP_EXT;
            CMD_INIT: cls.op = OP_INIT;
            default:  cls.op = OP_ACC;
        endcase
    end

    assign busy    = (cnt_reg == (QPtrW+1)'(QDepth));
    assign push    = start && !busy && (cmd != CMD_NONE);
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/gecs_back.sv =====
// back end: sum memory, per-group state and the command sequencer
`default_nettype none
module gecs_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire  [1:0]            element_type,
    input  wire  [5:0]            preset_length,
    input  wire                   q_valid,
    input  gecs_pkg::item_t       q_item,
    output logic                  q_pop,
    output logic                  idle,
    output logic                  strobe,
    output logic [2:0]            kind,
    output logic [4:0]            out_position,
    output logic [63:0]           sum_value,
    output logic                  last
);
    import gecs_pkg::*;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_ADD,
        ST_EXT
    } state_t;

    // sum memory: zeroed by a sweep after reset and per group on init
    logic [63:0]         mem [NumGroups*MaxLen];
    logic [63:0]         rd_data_reg;
    logic [LenW-1:0]     vlen_reg [NumGroups];
    logic [NumGroups-1:0] null_reg;

    state_t              state_reg;
    item_t               cur_reg;
    logic [PosW:0]       idx_reg;
    logic [LenW-1:0]     elen_reg;
    logic [AddrW-1:0]    clr_reg;

    logic [AddrW-1:0]    rd_addr;
    logic                rd_en;
    logic [AddrW-1:0]    wr_addr;
    logic [63:0]         wr_data;
    logic                wr_en;
    logic [63:0]         a_val, b_val, s_val, half_s;
    logic                ovf, below;
    logic [LenW-1:0]     pre_sat;
    logic                strobe_next;

    assign a_val  = narrow(rd_data_reg, element_type);
    assign b_val  = narrow(cur_reg.value, element_type);
    assign s_val  = a_val + b_val;
    assign half_s = narrow(s_val, element_type);
    assign ovf    = (element_type == ET_W64) ?
                    (((a_val ^ s_val) & (b_val ^ s_val)) >> 63) != 64'd0 :
                    (half_s != s_val);
    assign below  = (element_type == ET_W64) ? b_val[63] : s_val[63];
    assign pre_sat = (preset_length > LenW'(MaxLen)) ? LenW'(MaxLen) : preset_length;
    assign idle   = (state_reg == ST_IDLE) && !q_valid;

    // memory read address select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {q_item.grp, q_item.pos};
        if (state_reg == ST_IDLE && q_valid && q_item.op == OP_ACC)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == ST_IDLE && q_valid && q_item.op == OP_EXT)
        begin
            rd_en   = 1'b1;
            rd_addr = {q_item.grp, PosW'(0)};
        end
        else if (state_reg == ST_EXT)
        begin
            rd_en   = 1'b1;
            rd_addr = {cur_reg.grp, idx_reg[PosW-1:0] + 1'b1};
        end
    end

    // memory write select: clearing sweeps write zeros, the adder a sum without overflow
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {cur_reg.grp, cur_reg.pos};
        wr_data = s_val;
        if (state_reg inside {ST_WIPE, ST_CLEAR})
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == ST_ADD)
        begin
            wr_en = !ovf;
        end
    end

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // result strobe for the coming cycle
    always_comb
    begin
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.op == OP_CAP)
                begin
                    strobe_next = 1'b1;
                end
                else if (q_valid && q_item.op == OP_EXT &&
                         (null_reg[q_item.grp] || vlen_reg[q_item.grp] == '0))
                begin
                    strobe_next = 1'b1;
                end
            end
            ST_ADD:  strobe_next = ovf;
            ST_EXT:  strobe_next = 1'b1;
            default: strobe_next = 1'b0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_WIPE;
            null_reg     <= '1;
            cur_reg      <= '0;
            idx_reg      <= '0;
            elen_reg     <= '0;
            clr_reg      <= '0;
            strobe       <= 1'b0;
            kind         <= KIND_SUM;
            out_position <= '0;
            sum_value    <= '0;
            last         <= 1'b0;
            for (int g = 0; g < NumGroups; g++)
            begin
                vlen_reg[g] <= '0;
            end
        end
        else
        begin
            strobe <= strobe_next;
            case (state_reg)
                ST_WIPE:
                begin
                    // zero the whole sum memory, one entry per cycle
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_item;
                        case (q_item.op)
                            OP_CAP:
                            begin
                                kind         <= KIND_CAP;
                                out_position <= '0;
                                sum_value    <= '0;
                                last         <= 1'b1;
                            end
                            OP_INIT:
                            begin
                                null_reg[q_item.grp] <= 1'b1;
                                vlen_reg[q_item.grp] <= pre_sat;
                                clr_reg   <= {q_item.grp, PosW'(0)};
                                state_reg <= ST_CLEAR;
                            end
                            OP_EXT:
                            begin
                                if (null_reg[q_item.grp])
                                begin
                                    kind         <= KIND_NULL;
                                    out_position <= '0;
                                    sum_value    <= '0;
                                    last         <= 1'b1;
                                end
                                else if (vlen_reg[q_item.grp] == '0)
                                begin
                                    kind         <= KIND_EMPTY;
                                    out_position <= '0;
                                    sum_value    <= '0;
                                    last         <= 1'b1;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    elen_reg  <= vlen_reg[q_item.grp];
                                    state_reg <= ST_EXT;
                                end
                            end
                            default:
                            begin
                                null_reg[q_item.grp] <= 1'b0;
                                if (q_item.rlen > vlen_reg[q_item.grp])
                                begin
                                    vlen_reg[q_item.grp] <= q_item.rlen;
                                end
                                if (q_item.rlen != '0 && !q_item.enull &&
                                    LenW'(q_item.pos) < q_item.rlen)
                                begin
                                    state_reg <= ST_READ;
                                end
                            end
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    // zero the group's sums, one entry per cycle
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[PosW-1:0] == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (ovf)
                    begin
                        kind         <= below ? KIND_OVFL : KIND_OVFH;
                        out_position <= cur_reg.pos;
                        sum_value    <= a_val;
                        last         <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_EXT:
                begin
                    kind         <= KIND_SUM;
                    out_position <= idx_reg[PosW-1:0];
                    sum_value    <= a_val;
                    last         <= (LenW'(idx_reg) + 1'b1 == elen_reg);
                    idx_reg      <= idx_reg + 1'b1;
                    if (LenW'(idx_reg) + 1'b1 == elen_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/grouped_elementwise_checked_sum_checker.sv =====
// checker for the grouped checked sum block: predicts results and compares them
`default_nettype none
module grouped_elementwise_checked_sum_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire  [1:0]  cmd,
    input  wire  [3:0]  group,
    input  wire  [4:0]  position,
    input  wire  [5:0]  row_length,
    input  wire  [63:0] elem_value,
    input  wire         elem_null,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [5:0]  cfg_data,
    input  wire         strobe,
    input  wire  [2:0]  kind,
    input  wire  [4:0]  out_position,
    input  wire  [63:0] sum_value,
    input  wire         last,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    import gecs_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  pos;
        logic [63:0] val;
        logic        last;
    } res_t;

    res_t        expected_results[$];
    logic [63:0] sums [NumGroups*MaxLen];
    logic [5:0]  vec_len [NumGroups];
    logic        is_null [NumGroups];
    logic [1:0]  width_sel;
    logic [5:0]  init_len;

    assign pending = expected_results.size();

    // sign-extend the low configured bits
    function automatic logic [63:0] trim(input logic [63:0] v, input logic [1:0] et);
        case (et)
            ET_W8:   trim = {{56{v[7]}}, v[7:0]};
            ET_W16:  trim = {{48{v[15]}}, v[15:0]};
            ET_W32:  trim = {{32{v[31]}}, v[31:0]};
            default: trim = v;
        endcase
    endfunction

    function automatic res_t mk(input logic [2:0] k, input logic [4:0] p,
                                input logic [63:0] v, input logic l);
        res_t r;
        r.kind = k;
        r.pos  = p;
        r.val  = v;
        r.last = l;
        return r;
    endfunction

    // append one expected result to the tail of the queue
    task automatic expect_res(input res_t r);
        expected_results = {expected_results, r};
    endtask

    // update the shadow state for one command transfer and queue its results
    task automatic predict_sum(input logic [1:0] c, input logic [3:0] g, input logic [4:0] p,
                               input logic [5:0] rl, input logic [63:0] e, input logic en);
        int          base;
        int          n;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic        ovf;
        logic        below;
        base = g * MaxLen;
        if (c == CMD_INIT)
        begin
            for (int i = 0; i < MaxLen; i++)
                sums[base+i] = '0;
            vec_len[g] = (init_len > MaxLen) ? 6'(MaxLen) : init_len;
            is_null[g] = 1'b1;
        end
        else if (c == CMD_EXT)
        begin
            n = vec_len[g];
            if (is_null[g])
                expect_res(mk(KIND_NULL, '0, '0, 1'b1));
            else if (n == 0)
                expect_res(mk(KIND_EMPTY, '0, '0, 1'b1));
            else
            begin
                if (n > 32)
                    n = 32;
                for (int i = 0; i < n; i++)
                    expect_res(mk(KIND_SUM, 5'(i),
                        trim(sums[base+i], width_sel), i == n - 1));
            end
        end
        else if (c == CMD_ACC)
        begin
            if (rl > MaxLen)
                expect_res(mk(KIND_CAP, '0, '0, 1'b1));
            else
            begin
                is_null[g] = 1'b0;
                if (rl > vec_len[g])
                    vec_len[g] = rl;
                if (rl != 0 && p < rl && !en)
                begin
                    a = trim(sums[base+p], width_sel);
                    b = trim(e, width_sel);
                    s = a + b;
                    if (width_sel == ET_W64)
                    begin
                        ovf   = (((a ^ s) & (b ^ s)) >> 63) != 64'd0;
                        below = b[63];
                    end
                    else
                    begin
                        ovf   = (s + (64'd1 << ((8 << width_sel) - 1)))
                                >= (64'd1 << (8 << width_sel));
                        below = s[63];
                    end
                    if (ovf)
                        expect_res(mk(below ? KIND_OVFL : KIND_OVFH, p, a, 1'b1));
                    else
                        sums[base+p] = s;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NumGroups*MaxLen; i++)
                sums[i] = '0;
            for (int i = 0; i < NumGroups; i++)
            begin
                vec_len[i] = '0;
                is_null[i] = 1'b1;
            end
            width_sel = ET_W64;
            init_len  = '0;
            expected_results.delete();
            fail_count   = 0;
            result_count = 0;
        end
        else
        begin
            // result transfer check first, it cannot depend on this edge's command
            if (strobe)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result kind=%0d", kind);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d got %0d", exp_r.kind, kind);
                        fail_count++;
                    end
                    if (out_position !== exp_r.pos)
                    begin
                        $error("out_position: expected %0d got %0d", exp_r.pos,
                               out_position);
                        fail_count++;
                    end
                    if (sum_value !== exp_r.val)
                    begin
                        $error("sum_value: expected %0h got %0h", exp_r.val, sum_value);
                        fail_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last: expected %0d got %0d", exp_r.last, last);
                        fail_count++;
                    end
                end
            end
            // config transfer
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ELEM_TYPE)
                    width_sel = cfg_data[1:0];
                else
                    init_len = cfg_data;
            end
            // command transfer
            if (start && !busy)
                predict_sum(cmd, group, position, row_length, elem_value, elem_null);
        end
    end
endmodule
`default_nettype wire

// ===== tb/grouped_elementwise_checked_sum_tb.sv =====
// testbench top: stimulus, configuration phases and verdict for the checked sum block
`default_nettype none
module grouped_elementwise_checked_sum_tb;
    import gecs_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int DrainWait  = 400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [3:0]  group;
    logic [4:0]  position;
    logic [5:0]  row_length;
    logic [63:0] elem_value;
    logic        elem_null;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        strobe;
    logic [2:0]  kind;
    logic [4:0]  out_position;
    logic [63:0] sum_value;
    logic        last;
    int          fail_count;
    int          pending;
    int          result_count;
    int          cycles;
    int          sent;
    int          gap_pct;

    grouped_elementwise_checked_sum dut (.*);

    grouped_elementwise_checked_sum_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL grouped_elementwise_checked_sum");
                $finish;
            end
        end
    end

    // one command transfer, with a random gap before it
    task automatic send_cmd(input logic [1:0] c, input logic [3:0] g, input logic [4:0] p,
                            input logic [5:0] rl, input logic [63:0] e, input logic en);
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        cmd        = c;
        group      = g;
        position   = p;
        row_length = rl;
        elem_value = e;
        elem_null  = en;
        // busy is steady between rising edges, so the transfer edge is the next one
        while (busy)
            @(negedge clk);
        @(negedge clk);
        start = 1'b0;
        sent++;
    endtask

    // wait for all results, then for the back end to settle
    task automatic drain;
        while (pending != 0)
            @(negedge clk);
        repeat (DrainWait) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [5:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand_elem(input logic [1:0] et);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'h7fff_ffff_ffff_ffff;
            1: v = 64'h8000_0000_0000_0000;
            2: v = v >> (8 << et) - 4;
            3: v = -(v >> ((8 << et) - 4));
            default: ;
        endcase
        return v;
    endfunction

    // mostly well-formed rows into a few groups, with extracts and inits mixed in
    task automatic random_phase(input int n);
        int       r;
        logic [1:0] c;
        logic [5:0] rl;
        for (int i = 0; i < n; i++)
        begin
            r  = $urandom_range(99);
            rl = ($urandom_range(19) == 0) ? 6'($urandom_range(33, 63))
                                           : 6'($urandom_range(32));
            c  = (r < 70) ? CMD_ACC : (r < 85) ? CMD_EXT : (r < 95) ? CMD_INIT : CMD_NONE;
            send_cmd(c, 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(3)),
                     5'($urandom_range(31)), rl, rand_elem(2'($urandom_range(3))),
                     $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        start      = 1'b0;
        cmd        = CMD_ACC;
        group      = '0;
        position   = '0;
        row_length = '0;
        elem_value = '0;
        elem_null  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ELEM_TYPE;
        cfg_data   = '0;
        sent       = 0;
        gap_pct    = 0;
        rst_n      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: null, empty, overflow both ways, capacity, ignored elements
        send_cmd(CMD_EXT, 0, 0, 0, 0, 0);
        send_cmd(CMD_ACC, 0, 0, 0, 5, 0);
        send_cmd(CMD_EXT, 0, 0, 0, 0, 0);
        send_cmd(CMD_ACC, 1, 0, 2, 64'h7fff_ffff_ffff_ffff, 0);
        send_cmd(CMD_ACC, 1, 0, 2, 64'd1, 0);
        send_cmd(CMD_ACC, 1, 1, 2, 64'h8000_0000_0000_0000, 0);
        send_cmd(CMD_ACC, 1, 1, 2, 64'hffff_ffff_ffff_ffff, 0);
        send_cmd(CMD_ACC, 1, 5, 2, 64'd9, 0);
        send_cmd(CMD_ACC, 1, 1, 2, 64'd9, 1);
        send_cmd(CMD_ACC, 1, 31, 32, 64'd3, 0);
        send_cmd(CMD_ACC, 1, 0, 63, 64'd3, 0);
        send_cmd(CMD_ACC, 15, 0, 33, 64'd3, 0);
        send_cmd(CMD_NONE, 1, 0, 2, 64'd3, 0);
        send_cmd(CMD_EXT, 1, 0, 0, 0, 0);
        drain();
        write_cfg(CFG_ELEM_TYPE, 6'd0);
        write_cfg(CFG_PRESET_LEN, 6'd63);
        send_cmd(CMD_EXT, 1, 0, 0, 0, 0);
        send_cmd(CMD_INIT, 2, 0, 0, 0, 0);
        send_cmd(CMD_EXT, 2, 0, 0, 0, 0);
        send_cmd(CMD_ACC, 2, 3, 4, 64'h7f, 0);
        send_cmd(CMD_ACC, 2, 3, 4, 64'h1, 0);
        send_cmd(CMD_ACC, 2, 4, 5, 64'h80, 0);
        send_cmd(CMD_ACC, 2, 4, 5, 64'hff, 0);
        send_cmd(CMD_EXT, 2, 0, 0, 0, 0);

        // random phases across widths and preset lengths
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_cfg(CFG_ELEM_TYPE, 6'(ph % 4));
            write_cfg(CFG_PRESET_LEN, (ph == 5) ? 6'd32 : 6'($urandom_range(8)));
            gap_pct = (ph < 2) ? 37 : (ph < 4) ? 53 : 0;
            random_phase(42);
        end
        drain();

        $display("sent %0d commands across all widths, checked %0d results",
                 sent, result_count);
        if (fail_count == 0)
            $display("PASS grouped_elementwise_checked_sum");
        else
            $display("FAIL grouped_elementwise_checked_sum");
        $finish;
    end
endmodule
`default_nettype wire
